### hdl/rdc_pkg.sv
// Shared types, codes and the CRC-32 byte update for the record deframer.
// No dependencies; every other file imports this package.
package rdc_pkg;

  // header layout and defaults
  localparam int unsigned HeaderBytes    = 32;
  localparam int unsigned CheckPos       = HeaderBytes - 4;
  localparam int unsigned LengthBitsDflt = 16;
  localparam logic [31:0] CrcPoly        = 32'hEDB88320;
  localparam logic [31:0] CrcInit        = 32'hFFFFFFFF;
  localparam logic [31:0] ValidMark      = 32'd1;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_KEY,
    PH_KCHK,
    PH_VAL,
    PH_VCHK
  } phase_e;

  // section code reported with each byte
  typedef enum logic [2:0] {
    SEC_HDR  = 3'd0,
    SEC_KEY  = 3'd1,
    SEC_KCHK = 3'd2,
    SEC_VAL  = 3'd3,
    SEC_VCHK = 3'd4,
    SEC_IGN  = 3'd5
  } section_e;

  // status code reported with each byte
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_VALID = 3'd1,
    ST_HDR_BAD   = 3'd2,
    ST_KEY_BAD   = 3'd3,
    ST_VAL_BAD   = 3'd4,
    ST_TOO_LARGE = 3'd5
  } status_e;

  // input request
  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_record;
  } in_req_t;

  // result request
  typedef struct packed {
    logic [7:0]  out_byte;
    section_e    section;
    status_e     status;
    logic        record_end;
    logic [15:0] key_length;
    logic [15:0] value_length;
    logic [15:0] padding_length;
  } out_req_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
    end
    return x;
  endfunction

endpackage

### hdl/record_deframer_crc32_check.sv
// Record deframer with CRC-32 checks, top level: parser plus output and skid
// registers. Depends on rdc_pkg and rdc_parser.
//
// Takes one record byte per request and returns exactly one result per byte:
// the byte itself, its section, a status and the header lengths. A byte with
// start_of_record set restarts the parser as header byte 0. The 32-byte
// header is checked on its last byte (valid word, header CRC, length bound of
// 2^LENGTH_BITS-1); key and value bytes each carry a 4-byte reflected CRC-32
// checked on the last check byte; a key CRC error is reported on the last value
// check byte. After a record ends, bytes are reported as ignored until the next
// start flag. Throughput is one byte per cycle while in_stall_o is low; the
// result is registered in the output register, or in a skid register that lets
// the input take one more byte while the output is stalled.
module record_deframer_crc32_check import rdc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDflt
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  logic     accept, out_take, out_load;
  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  out_req_t res, out_q, out_d, skid_q;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_load   = !out_valid_q || out_take;

  rdc_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .res_o    (res)
  );

  // output and skid control
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    if (out_load) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = accept;
      end
    end else if (accept) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept && !out_load) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // skid only fills behind a held result
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid request without an output request");

  // a request taken while the output stalls lands in the skid
  a_stall_to_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("request lost while output stalled");

  // an error status always closes the record
  a_err_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_req_o.status != ST_OK)) |-> out_req_o.record_end)
    else $error("error status without record end");

  // a record only ends on a header or value check byte
  a_end_section : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.record_end) |->
      (out_req_o.section == SEC_HDR || out_req_o.section == SEC_VCHK))
    else $error("record end in wrong section");

endmodule

### hdl/rdc_parser.sv
// Record parser: phase, counters, header fields and running CRC, plus the
// per-byte result logic. Depends on rdc_pkg.
module rdc_parser import rdc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDflt
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_req_t  req_i,
  output out_req_t res_o
);

  localparam int unsigned CntW = LENGTH_BITS;
  localparam logic [CntW-1:0] HdrLast  = CntW'(HeaderBytes - 1);
  localparam logic [CntW-1:0] HdrCrcEnd = CntW'(CheckPos);

  phase_e          phase_q, phase_d, ph;
  logic [CntW-1:0] cnt_q, cnt_d, cnt;
  logic [CntW:0]   cnt_inc;
  logic [31:0]     valid_q, valid_d, vw;
  logic [31:0]     key_q, key_d, key_e;
  logic [31:0]     val_q, val_d, val_e;
  logic [31:0]     pad_q, pad_d, pad_e;
  logic [31:0]     crc_q, crc_d, crc;
  logic [31:0]     chk_q, chk_d, chk;
  logic            kbad_q, kbad_d, kbad;
  logic            show, bad, too_large;
  logic [CntW:0]   len_lim;

  function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] idx,
                                           logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[{idx, 3'b000} +: 8] = b;
    return r;
  endfunction

  // start flag clears the record state
  always_comb begin
    ph    = req_i.start_of_record ? PH_HDR : phase_q;
    cnt   = req_i.start_of_record ? '0 : cnt_q;
    vw    = req_i.start_of_record ? '0 : valid_q;
    key_e = req_i.start_of_record ? '0 : key_q;
    val_e = req_i.start_of_record ? '0 : val_q;
    pad_e = req_i.start_of_record ? '0 : pad_q;
    crc   = req_i.start_of_record ? CrcInit : crc_q;
    chk   = req_i.start_of_record ? '0 : chk_q;
    kbad  = req_i.start_of_record ? 1'b0 : kbad_q;
  end

  assign cnt_inc   = {1'b0, cnt} + {{CntW{1'b0}}, 1'b1};
  assign too_large = ((key_e >> LENGTH_BITS) != '0) || ((val_e >> LENGTH_BITS) != '0);
  assign len_lim   = (ph == PH_KEY) ? {1'b0, key_e[CntW-1:0]} : {1'b0, val_e[CntW-1:0]};

  // next state and result
  always_comb begin
    phase_d = ph;
    cnt_d   = cnt;
    valid_d = vw;
    key_d   = key_e;
    val_d   = val_e;
    pad_d   = pad_e;
    crc_d   = crc;
    chk_d   = chk;
    kbad_d  = kbad;
    show    = 1'b0;
    bad     = 1'b0;
    res_o.out_byte   = req_i.in_byte;
    res_o.section    = SEC_IGN;
    res_o.status     = ST_OK;
    res_o.record_end = 1'b0;
    case (ph)
      PH_HDR: begin
        res_o.section = SEC_HDR;
        if (cnt < HdrCrcEnd) begin
          crc_d = crc32_byte(crc, req_i.in_byte);
        end
        case (cnt[4:2])
          3'd0:    valid_d = put_byte(vw, cnt[1:0], req_i.in_byte);
          3'd1:    key_d   = put_byte(key_e, cnt[1:0], req_i.in_byte);
          3'd2:    val_d   = put_byte(val_e, cnt[1:0], req_i.in_byte);
          3'd3:    pad_d   = put_byte(pad_e, cnt[1:0], req_i.in_byte);
          3'd7:    chk_d   = put_byte(chk, cnt[1:0], req_i.in_byte);
          default: ;
        endcase
        cnt_d = cnt_inc[CntW-1:0];
        if (cnt == HdrLast) begin
          if (vw != ValidMark) begin
            res_o.status = ST_NOT_VALID;
          end else if (~crc != chk_d) begin
            res_o.status = ST_HDR_BAD;
          end else if (too_large) begin
            res_o.status = ST_TOO_LARGE;
          end
          if (res_o.status != ST_OK) begin
            res_o.record_end = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            show    = 1'b1;
            cnt_d   = '0;
            crc_d   = CrcInit;
            chk_d   = '0;
            phase_d = (key_e != '0) ? PH_KEY : PH_KCHK;
          end
        end
      end
      PH_KEY, PH_VAL: begin
        res_o.section = (ph == PH_KEY) ? SEC_KEY : SEC_VAL;
        show  = 1'b1;
        crc_d = crc32_byte(crc, req_i.in_byte);
        cnt_d = cnt_inc[CntW-1:0];
        if (cnt_inc >= len_lim) begin
          cnt_d   = '0;
          chk_d   = '0;
          phase_d = (ph == PH_KEY) ? PH_KCHK : PH_VCHK;
        end
      end
      PH_KCHK, PH_VCHK: begin
        res_o.section = (ph == PH_KCHK) ? SEC_KCHK : SEC_VCHK;
        show  = 1'b1;
        chk_d = put_byte(chk, cnt[1:0], req_i.in_byte);
        cnt_d = cnt_inc[CntW-1:0];
        if (cnt[1:0] == 2'd3) begin
          bad   = (~crc != chk_d);
          cnt_d = '0;
          chk_d = '0;
          crc_d = CrcInit;
          if (ph == PH_KCHK) begin
            if (bad) begin
              kbad_d = 1'b1;
            end
            phase_d = (val_e != '0) ? PH_VAL : PH_VCHK;
          end else begin
            res_o.status     = kbad ? ST_KEY_BAD : (bad ? ST_VAL_BAD : ST_OK);
            res_o.record_end = 1'b1;
            phase_d          = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
    res_o.key_length     = show ? key_d[15:0] : '0;
    res_o.value_length   = show ? val_d[15:0] : '0;
    res_o.padding_length = show ? pad_d[15:0] : '0;
  end

  // record state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      valid_q <= '0;
      key_q   <= '0;
      val_q   <= '0;
      pad_q   <= '0;
      crc_q   <= CrcInit;
      chk_q   <= '0;
      kbad_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      key_q   <= key_d;
      val_q   <= val_d;
      pad_q   <= pad_d;
      crc_q   <= crc_d;
      chk_q   <= chk_d;
      kbad_q  <= kbad_d;
    end
  end

endmodule
